// File: hw/rtl/mbcl_pkg.sv
// Package: shared types, constants and the blink-plan lookup for the mode blink-code LED.
package mbcl_pkg;

   localparam int unsigned DurW      = 16;
   localparam int unsigned TimeW     = 32;
   localparam int unsigned ModeW     = 5;
   localparam int unsigned PulseW    = 5;
   localparam int unsigned CsrAddrW  = 3;
   localparam int unsigned ModeCntW  = 7;
   localparam int unsigned DefModeCount = 32;
   localparam int unsigned ReqDataW  = 40;
   localparam int unsigned RspDataW  = 8;

   // Longest pattern over all 5-bit modes: user number 29 gives 2 long + 9 short.
   localparam logic [PulseW-1:0] MaxPulses = 5'd11;

   localparam logic [DurW-1:0] RstShortOn  = 16'd200;
   localparam logic [DurW-1:0] RstLongOn   = 16'd800;
   localparam logic [DurW-1:0] RstGapShort = 16'd400;
   localparam logic [DurW-1:0] RstGapLong  = 16'd400;
   localparam logic [DurW-1:0] RstPause    = 16'd1200;

   typedef enum logic [1:0] {
      CMD_TICK     = 2'd0,
      CMD_SET_MODE = 2'd1,
      CMD_SET_OVR  = 2'd2,
      CMD_RESTART  = 2'd3
   } cmd_type;

   typedef enum logic [CsrAddrW-1:0] {
      CSR_SHORT_ON  = 3'd0,
      CSR_LONG_ON   = 3'd1,
      CSR_GAP_SHORT = 3'd2,
      CSR_GAP_LONG  = 3'd3,
      CSR_PAUSE     = 3'd4
   } csr_addr_type;

   typedef struct packed {
      logic [1:0] tens;   // long pulses at the head of the pattern
      logic [3:0] total;  // long plus short pulses
   } plan_type;

   // User number u = mode + 1; tens long pulses, then (u mod 10) short ones.
   function automatic plan_type blink_plan(input logic [ModeW-1:0] mode);
      logic [5:0] u;
      logic [1:0] t;
      logic [5:0] units;
      plan_type   p;
      u = {1'b0, mode} + 6'd1;
      if (u >= 6'd30) begin
         t = 2'd3;
      end else if (u >= 6'd20) begin
         t = 2'd2;
      end else if (u >= 6'd10) begin
         t = 2'd1;
      end else begin
         t = 2'd0;
      end
      units   = u - 6'(t) * 6'd10;
      p.tens  = t;
      p.total = 4'(units) + 4'(t);
      return p;
   endfunction

   function automatic logic [DurW-1:0] at_least_one(input logic [DurW-1:0] v);
      return (v == '0) ? DurW'(1) : v;
   endfunction

endpackage

// File: hw/rtl/mode_blink_code_led.sv
// Top level: mode blink-code LED sequencer with stream input/output and config write port.
// A status LED blinks the user number (mode + 1): below 10 as that many short pulses,
// from 10 up as the tens in long pulses followed by the units in short pulses, then a
// dark sequence pause, over and over. Each request carries a millisecond timestamp and
// a command (tick, set mode, set override, restart); every request yields exactly one
// response with the LED level, pulses completed and override status after that request.
// Timing: a request is captured in an input register, evaluated against the sequencer
// state combinationally, and the response lands in an output register; one request is
// taken every cycle while the response side keeps up. The critical path is the 32-bit
// elapsed-time subtraction and its compare against a 16-bit duration. While the response
// is not taken, an empty input register still takes one request; after that both stages
// stall. Write the duration registers only while no request is in flight.
module mode_blink_code_led #(
   parameter int unsigned MODE_COUNT = mbcl_pkg::DefModeCount  // 1..99
) (
   input  logic                          clock,
   input  logic                          reset,
   // request stream
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // tdata, from bit 0: time_ms[31:0], mode[36:32], override_on[37],
   //                     override_level[38], zero pad[39]
   input  logic [mbcl_pkg::ReqDataW-1:0] req_tdata,
   // tuser, from bit 0: cmd[1:0]
   input  logic [1:0]                    req_tuser,
   // response stream
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // tdata, from bit 0: led_on[0], pulses completed[5:1], override in force[6],
   //                     zero pad[7]
   output logic [mbcl_pkg::RspDataW-1:0] rsp_tdata,
   // config write port
   input  logic                          csr_we,
   input  logic [mbcl_pkg::CsrAddrW-1:0] csr_addr,
   input  logic [mbcl_pkg::DurW-1:0]     csr_wdata
);

   localparam int unsigned DurW   = mbcl_pkg::DurW;
   localparam int unsigned TimeW  = mbcl_pkg::TimeW;
   localparam int unsigned ModeW  = mbcl_pkg::ModeW;
   localparam int unsigned PulseW = mbcl_pkg::PulseW;

   // ---------------------------------------------------------------- config
   logic [DurW-1:0] short_on_ff, long_on_ff, gap_short_ff, gap_long_ff, pause_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         short_on_ff  <= mbcl_pkg::RstShortOn;
         long_on_ff   <= mbcl_pkg::RstLongOn;
         gap_short_ff <= mbcl_pkg::RstGapShort;
         gap_long_ff  <= mbcl_pkg::RstGapLong;
         pause_ff     <= mbcl_pkg::RstPause;
      end else if (csr_we) begin
         // indexes past the register list are dropped
         unique case (mbcl_pkg::csr_addr_type'(csr_addr))
            mbcl_pkg::CSR_SHORT_ON:  short_on_ff  <= csr_wdata;
            mbcl_pkg::CSR_LONG_ON:   long_on_ff   <= csr_wdata;
            mbcl_pkg::CSR_GAP_SHORT: gap_short_ff <= csr_wdata;
            mbcl_pkg::CSR_GAP_LONG:  gap_long_ff  <= csr_wdata;
            mbcl_pkg::CSR_PAUSE:     pause_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------- input stage
   logic                  in_valid_ff;
   mbcl_pkg::cmd_type     in_cmd_ff;
   logic [TimeW-1:0]      in_time_ff;
   logic [ModeW-1:0]      in_mode_ff;
   logic                  in_ovr_on_ff;
   logic                  in_ovr_lvl_ff;

   logic rsp_valid_ff;
   logic advance;

   // The evaluate stage moves whenever the response slot is empty or being drained.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_cmd_ff     <= mbcl_pkg::cmd_type'(req_tuser);
         in_time_ff    <= req_tdata[TimeW-1:0];
         in_mode_ff    <= req_tdata[TimeW +: ModeW];
         in_ovr_on_ff  <= req_tdata[TimeW+ModeW];
         in_ovr_lvl_ff <= req_tdata[TimeW+ModeW+1];
      end
   end

   // ------------------------------------------------------- sequencer state
   logic [TimeW-1:0]  last_time_ff, last_time_in;
   logic              led_ff, led_in;
   logic [PulseW-1:0] done_ff, done_in;
   logic [DurW-1:0]   on_dur_ff, on_dur_in;
   logic [DurW-1:0]   off_gap_ff, off_gap_in;
   logic [ModeW-1:0]  mode_ff, mode_in;
   logic              ovr_flag_ff, ovr_flag_in;
   logic              ovr_val_ff, ovr_val_in;

   mbcl_pkg::plan_type plan;
   logic [TimeW-1:0]   elapsed;
   logic               seq_done;
   logic               pulse_long;
   logic               mode_ok;

   assign plan       = mbcl_pkg::blink_plan(mode_ff);
   assign elapsed    = in_time_ff - last_time_ff;
   assign seq_done   = done_ff >= PulseW'(plan.total);
   assign pulse_long = done_ff < PulseW'(plan.tens);
   assign mode_ok    = {2'b00, in_mode_ff} < mbcl_pkg::ModeCntW'(MODE_COUNT);

   always_comb begin
      last_time_in = last_time_ff;
      led_in       = led_ff;
      done_in      = done_ff;
      on_dur_in    = on_dur_ff;
      off_gap_in   = off_gap_ff;
      mode_in      = mode_ff;
      ovr_flag_in  = ovr_flag_ff;
      ovr_val_in   = ovr_val_ff;
      unique case (in_cmd_ff)
         mbcl_pkg::CMD_TICK: begin
            if (ovr_flag_ff) begin
               led_in = ovr_val_ff;
            end else if (seq_done) begin
               // pattern finished: stay dark through the pause, then start over
               led_in = 1'b0;
               if (elapsed >= TimeW'(pause_ff)) begin
                  done_in      = '0;
                  off_gap_in   = mbcl_pkg::at_least_one(gap_short_ff);
                  last_time_in = in_time_ff;
               end
            end else if (!led_ff) begin
               if (elapsed >= TimeW'(mbcl_pkg::at_least_one(off_gap_ff))) begin
                  on_dur_in    = mbcl_pkg::at_least_one(pulse_long ? long_on_ff
                                                                   : short_on_ff);
                  led_in       = 1'b1;
                  last_time_in = in_time_ff;
               end
            end else begin
               if (elapsed >= TimeW'(on_dur_ff)) begin
                  led_in       = 1'b0;
                  last_time_in = in_time_ff;
                  done_in      = done_ff + PulseW'(1);
                  off_gap_in   = mbcl_pkg::at_least_one(pulse_long ? gap_long_ff
                                                                   : gap_short_ff);
               end
            end
         end
         mbcl_pkg::CMD_SET_MODE: begin
            if (mode_ok) begin
               mode_in = in_mode_ff;
               if (in_mode_ff != mode_ff && !ovr_flag_ff) begin
                  done_in      = '0;
                  off_gap_in   = mbcl_pkg::at_least_one(gap_short_ff);
                  last_time_in = in_time_ff;
                  led_in       = 1'b0;
               end
            end
         end
         mbcl_pkg::CMD_SET_OVR: begin
            ovr_flag_in = in_ovr_on_ff;
            ovr_val_in  = in_ovr_lvl_ff;
            if (in_ovr_on_ff) begin
               led_in = in_ovr_lvl_ff;
            end else if (ovr_flag_ff) begin
               // leaving override restarts the pattern
               done_in      = '0;
               off_gap_in   = mbcl_pkg::at_least_one(gap_short_ff);
               last_time_in = in_time_ff;
               led_in       = 1'b0;
            end
         end
         mbcl_pkg::CMD_RESTART: begin
            if (!ovr_flag_ff) begin
               done_in      = '0;
               off_gap_in   = mbcl_pkg::at_least_one(gap_short_ff);
               last_time_in = in_time_ff;
               led_in       = 1'b0;
            end
         end
         default: ;
      endcase
   end

   logic step;
   assign step = in_valid_ff && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_time_ff <= '0;
         led_ff       <= 1'b0;
         done_ff      <= '0;
         on_dur_ff    <= mbcl_pkg::RstShortOn;
         off_gap_ff   <= mbcl_pkg::RstGapShort;
         mode_ff      <= '0;
         ovr_flag_ff  <= 1'b0;
         ovr_val_ff   <= 1'b0;
      end else if (step) begin
         last_time_ff <= last_time_in;
         led_ff       <= led_in;
         done_ff      <= done_in;
         on_dur_ff    <= on_dur_in;
         off_gap_ff   <= off_gap_in;
         mode_ff      <= mode_in;
         ovr_flag_ff  <= ovr_flag_in;
         ovr_val_ff   <= ovr_val_in;
      end
   end

   // -------------------------------------------------------- response stage
   localparam int unsigned RspDataW_L = mbcl_pkg::RspDataW;
   logic [RspDataW_L-1:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= {1'b0, ovr_flag_in, done_in, led_in};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ------------------------------------------------------------ assertions
   a_done_bounded: assert property (@(posedge clock) disable iff (reset)
      done_ff <= mbcl_pkg::MaxPulses)
      else $error("pulse count ran past the longest pattern");

   a_gap_nonzero: assert property (@(posedge clock) disable iff (reset)
      (off_gap_ff != '0) && (on_dur_ff != '0))
      else $error("a zero duration reached the sequencer state");

   a_ovr_level: assert property (@(posedge clock) disable iff (reset)
      ovr_flag_ff |-> (led_ff == ovr_val_ff))
      else $error("LED left the override level while override is in force");

   a_step_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      step |=> (rsp_tvalid && rsp_tdata[0] == led_ff && rsp_tdata[6] == ovr_flag_ff))
      else $error("response does not match the updated state");

endmodule

// File: verif/tb_mode_blink_code_led.sv
// Testbench for the mode blink-code LED sequencer: stream stimulus, status prediction, compare.
`timescale 1ns / 1ps

// One LED status word, laid out as on rsp_tdata[6:0]
typedef struct packed {
   logic       ovr_held;
   logic [4:0] done_count;
   logic       led_on;
} led_status_type;

// Tracks the blink pattern per request and matches the LED status words
class led_code_scoreboard;
   logic [15:0] dur_reg [5];
   logic [31:0] mark_time;
   logic        lit;
   logic [4:0]  pulses_done;
   logic [15:0] on_len;
   logic [15:0] dark_len;
   logic [4:0]  mode_sel;
   logic        hold_on;
   logic        hold_level;
   led_status_type led_status_q [$];
   int          errors;

   function new();
      dur_reg[mbcl_pkg::CSR_SHORT_ON]  = mbcl_pkg::RstShortOn;
      dur_reg[mbcl_pkg::CSR_LONG_ON]   = mbcl_pkg::RstLongOn;
      dur_reg[mbcl_pkg::CSR_GAP_SHORT] = mbcl_pkg::RstGapShort;
      dur_reg[mbcl_pkg::CSR_GAP_LONG]  = mbcl_pkg::RstGapLong;
      dur_reg[mbcl_pkg::CSR_PAUSE]     = mbcl_pkg::RstPause;
      mark_time   = '0;
      lit         = 1'b0;
      pulses_done = '0;
      on_len      = mbcl_pkg::RstShortOn;
      dark_len    = mbcl_pkg::RstGapShort;
      mode_sel    = '0;
      hold_on     = 1'b0;
      hold_level  = 1'b0;
      errors      = 0;
   endfunction

   function void set_reg(mbcl_pkg::csr_addr_type addr, logic [15:0] value);
      dur_reg[addr] = value;
   endfunction

   function int unsigned outstanding();
      return led_status_q.size();
   endfunction

   function logic [15:0] floor_one(logic [15:0] v);
      return (v == 16'd0) ? 16'd1 : v;
   endfunction

   function int unsigned user_num();
      return int'(mode_sel) + 1;
   endfunction

   function int unsigned pattern_length();
      int unsigned u;
      u = user_num();
      if (u < 10) begin
         return u;
      end
      return u / 10 + u % 10;
   endfunction

   function logic is_long_pulse(int unsigned idx);
      int unsigned u;
      u = user_num();
      if (u < 10) begin
         return 1'b0;
      end
      return idx < u / 10;
   endfunction

   function void restart_pattern(logic [31:0] now);
      if (hold_on) begin
         return;
      end
      pulses_done = '0;
      dark_len    = floor_one(dur_reg[mbcl_pkg::CSR_GAP_SHORT]);
      mark_time   = now;
      lit         = 1'b0;
   endfunction

   function void advance_pattern(logic [31:0] now);
      logic [31:0] elapsed;
      logic        was_long;
      if (hold_on) begin
         lit = hold_level;
         return;
      end
      elapsed = now - mark_time;
      // pattern finished: stay dark through the pause, then start over
      if (pulses_done >= pattern_length()) begin
         if (elapsed >= {16'd0, dur_reg[mbcl_pkg::CSR_PAUSE]}) begin
            pulses_done = '0;
            dark_len    = floor_one(dur_reg[mbcl_pkg::CSR_GAP_SHORT]);
            mark_time   = now;
            lit         = 1'b0;
            elapsed     = '0;
         end else begin
            lit = 1'b0;
            return;
         end
      end
      if (!lit) begin
         if (elapsed >= {16'd0, floor_one(dark_len)}) begin
            on_len    = floor_one(is_long_pulse(pulses_done) ?
                                  dur_reg[mbcl_pkg::CSR_LONG_ON] :
                                  dur_reg[mbcl_pkg::CSR_SHORT_ON]);
            lit       = 1'b1;
            mark_time = now;
         end
      end else if (elapsed >= {16'd0, on_len}) begin
         was_long    = is_long_pulse(pulses_done);
         lit         = 1'b0;
         mark_time   = now;
         pulses_done = pulses_done + 5'd1;
         dark_len    = was_long ? floor_one(dur_reg[mbcl_pkg::CSR_GAP_LONG]) :
                                  floor_one(dur_reg[mbcl_pkg::CSR_GAP_SHORT]);
      end
   endfunction

   function void apply_request(mbcl_pkg::cmd_type cmd, logic [31:0] now, logic [4:0] mode,
                               logic ovr_on, logic ovr_level);
      logic           was_held;
      led_status_type st;
      case (cmd)
         mbcl_pkg::CMD_TICK: begin
            advance_pattern(now);
         end
         mbcl_pkg::CMD_SET_MODE: begin
            if (32'(mode) < mbcl_pkg::DefModeCount) begin
               if (mode != mode_sel && !hold_on) begin
                  mode_sel = mode;
                  restart_pattern(now);
               end else begin
                  mode_sel = mode;
               end
            end
         end
         mbcl_pkg::CMD_SET_OVR: begin
            was_held   = hold_on;
            hold_on    = ovr_on;
            hold_level = ovr_level;
            if (ovr_on) begin
               lit = ovr_level;
            end else if (was_held) begin
               restart_pattern(now);
            end
         end
         default: begin
            restart_pattern(now);
         end
      endcase
      st.led_on     = lit;
      st.done_count = pulses_done;
      st.ovr_held   = hold_on;
      led_status_q.push_back(st);
   endfunction

   function void compare_status(logic [7:0] word);
      led_status_type exp_st;
      led_status_type got_st;
      got_st = word[6:0];
      if (led_status_q.size() == 0) begin
         $error("LED status 0x%0h arrived with nothing expected", word);
         errors++;
         return;
      end
      exp_st = led_status_q.pop_front();
      if (got_st.led_on !== exp_st.led_on) begin
         $error("led_on: expected %0d, got %0d", exp_st.led_on, got_st.led_on);
         errors++;
      end
      if (got_st.done_count !== exp_st.done_count) begin
         $error("done_count: expected %0d, got %0d", exp_st.done_count, got_st.done_count);
         errors++;
      end
      if (got_st.ovr_held !== exp_st.ovr_held) begin
         $error("ovr_held: expected %0d, got %0d",
                exp_st.ovr_held, got_st.ovr_held);
         errors++;
      end
   endfunction
endclass

module tb_mode_blink_code_led;

   // Generous bound on the length of the slowest legal run
   localparam int unsigned CycleLimit = 1_000_000;
   localparam int unsigned PhaseItems = 320;

   logic                          clock      = 1'b0;
   logic                          reset      = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [mbcl_pkg::ReqDataW-1:0] req_tdata  = '0;
   logic [1:0]                    req_tuser  = mbcl_pkg::CMD_TICK;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [mbcl_pkg::RspDataW-1:0] rsp_tdata;
   logic                          csr_we     = 1'b0;
   logic [mbcl_pkg::CsrAddrW-1:0] csr_addr   = mbcl_pkg::CSR_SHORT_ON;
   logic [mbcl_pkg::DurW-1:0]     csr_wdata  = '0;

   led_code_scoreboard sb;
   bit                 calm        = 1'b0;   // no gaps on either side while set
   int unsigned        cycle_count = 0;
   int                 stall_left  = 0;

   mode_blink_code_led u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Hard stop in case a transfer never completes
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Idle length for either side: mostly none or short, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 65) begin
         return 0;
      end
      if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // Result side: check every completed transfer, then pick the next ready level.
   // Only one nonblocking assignment to rsp_tready per edge.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            sb.compare_status(rsp_tdata);
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            stall_left = pick_gap();
            rsp_tready <= (stall_left == 0);
            if (stall_left > 0) begin
               stall_left--;
            end
         end
      end
   end

   // Present one request, optionally after an idle gap, and hold it until the transfer.
   // tvalid stays high on return so back-to-back requests never drop it mid-step.
   task automatic send_request(input mbcl_pkg::cmd_type cmd, input logic [31:0] now,
                               input logic [4:0] mode, input logic ovr_on,
                               input logic ovr_level);
      int gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {1'b0, ovr_level, ovr_on, mode, now};
      do @(posedge clock); while (!req_tready);
      sb.apply_request(cmd, now, mode, ovr_on, ovr_level);
   endtask

   // Drop tvalid and hold off until every outstanding status has been checked
   task automatic drain_requests();
      req_tvalid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      // two-stage pipeline: a few spare edges catch any stray response
      repeat (4) @(posedge clock);
   endtask

   // Write all five duration registers on consecutive edges; only while idle
   task automatic program_durations(input logic [15:0] short_on, input logic [15:0] long_on,
                                    input logic [15:0] gap_short, input logic [15:0] gap_long,
                                    input logic [15:0] pause);
      logic [15:0] vals [5];
      mbcl_pkg::csr_addr_type addr;
      vals[mbcl_pkg::CSR_SHORT_ON]  = short_on;
      vals[mbcl_pkg::CSR_LONG_ON]   = long_on;
      vals[mbcl_pkg::CSR_GAP_SHORT] = gap_short;
      vals[mbcl_pkg::CSR_GAP_LONG]  = gap_long;
      vals[mbcl_pkg::CSR_PAUSE]     = pause;
      for (int i = 0; i < 5; i++) begin
         addr = mbcl_pkg::csr_addr_type'(i);
         csr_we    <= 1'b1;
         csr_addr  <= addr;
         csr_wdata <= vals[addr];
         sb.set_reg(addr, vals[addr]);
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // Hand-picked walk through the pattern with the reset durations
   // (short on 200, long on 800, gaps 400, pause 1200)
   task automatic run_directed();
      send_request(mbcl_pkg::CMD_TICK,     32'd0,    5'd0,  1'b0, 1'b0);  // dark, gap open
      send_request(mbcl_pkg::CMD_TICK,     32'd400,  5'd0,  1'b0, 1'b0);  // short pulse lights
      send_request(mbcl_pkg::CMD_TICK,     32'd599,  5'd0,  1'b0, 1'b0);  // one short of on time
      send_request(mbcl_pkg::CMD_TICK,     32'd600,  5'd0,  1'b0, 1'b0);  // pattern done
      send_request(mbcl_pkg::CMD_TICK,     32'd1000, 5'd0,  1'b0, 1'b0);  // inside the pause
      send_request(mbcl_pkg::CMD_TICK,     32'd1800, 5'd0,  1'b0, 1'b0);  // pause over
      send_request(mbcl_pkg::CMD_SET_MODE, 32'd1900, 5'd9,  1'b1, 1'b1);  // user 10: one long
      send_request(mbcl_pkg::CMD_TICK,     32'd2300, 5'd0,  1'b0, 1'b0);  // long pulse lights
      send_request(mbcl_pkg::CMD_TICK,     32'd3100, 5'd0,  1'b0, 1'b0);  // long pulse ends
      send_request(mbcl_pkg::CMD_SET_MODE, 32'd3150, 5'd9,  1'b0, 1'b0);  // same mode, no restart
      send_request(mbcl_pkg::CMD_SET_MODE, 32'd3200, 5'd31, 1'b0, 1'b0);  // highest mode
      send_request(mbcl_pkg::CMD_SET_OVR,  32'd3300, 5'd0,  1'b1, 1'b1);  // override on, lit
      send_request(mbcl_pkg::CMD_SET_MODE, 32'd3400, 5'd28, 1'b0, 1'b0);  // stored under override
      send_request(mbcl_pkg::CMD_TICK,     32'd3500, 5'd31, 1'b1, 1'b1);  // tick holds the level
      send_request(mbcl_pkg::CMD_SET_OVR,  32'd3550, 5'd0,  1'b1, 1'b0);  // level change held
      send_request(mbcl_pkg::CMD_RESTART,  32'd3600, 5'd0,  1'b0, 1'b0);  // ignored under override
      send_request(mbcl_pkg::CMD_SET_OVR,  32'd3700, 5'd0,  1'b0, 1'b1);  // leaving restarts
      send_request(mbcl_pkg::CMD_SET_OVR,  32'd3800, 5'd0,  1'b0, 1'b0);  // off while off
      send_request(mbcl_pkg::CMD_RESTART,  32'hFFFF_FFF0, 5'd0, 1'b0, 1'b0);
      send_request(mbcl_pkg::CMD_TICK,     32'h0000_0190, 5'd0, 1'b0, 1'b0);  // across the wrap
      send_request(mbcl_pkg::CMD_TICK,     32'hFFFF_FFFF, 5'd0, 1'b0, 1'b0);  // huge elapsed
      send_request(mbcl_pkg::CMD_SET_MODE, 32'd0,    5'd0,  1'b0, 1'b0);  // lowest mode
      send_request(mbcl_pkg::CMD_TICK,     32'd5000, 5'd31, 1'b1, 1'b1);  // unused fields ones
      drain_requests();
   endtask

   // Mostly ticks on an advancing clock so patterns run to completion; sparse commands
   // and the odd time jump break them up. Steps scale with the longest duration.
   task automatic run_random(input int unsigned count, input bit hold_midway);
      logic [31:0]       now;
      logic [31:0]       step_max;
      logic [15:0]       longest;
      mbcl_pkg::cmd_type cmd;
      int                r;
      logic              ovr_on;
      longest = 16'd0;
      for (int i = 0; i < 5; i++) begin
         if (sb.dur_reg[i] > longest) begin
            longest = sb.dur_reg[i];
         end
      end
      step_max = {16'd0, longest} / 2 + 1;
      now = $urandom;
      for (int unsigned i = 0; i < count; i++) begin
         if (hold_midway && i == count / 2) begin
            drain_requests();
         end
         r = $urandom_range(0, 99);
         if (r < 3) begin
            now = $urandom;
         end else if (r >= 13) begin
            now = now + $urandom_range(1, step_max);
         end
         r = $urandom_range(0, 99);
         if (r < 93) begin
            cmd = mbcl_pkg::CMD_TICK;
         end else if (r < 96) begin
            cmd = mbcl_pkg::CMD_SET_MODE;
         end else if (r < 99) begin
            cmd = mbcl_pkg::CMD_SET_OVR;
         end else begin
            cmd = mbcl_pkg::CMD_RESTART;
         end
         // keep override mostly off so the pattern gets room to run
         ovr_on = (cmd == mbcl_pkg::CMD_SET_OVR) ? ($urandom_range(0, 2) == 0)
                                                 : 1'($urandom);
         send_request(cmd, now, 5'($urandom_range(0, 31)), ovr_on, 1'($urandom));
      end
      drain_requests();
   endtask

   initial begin
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();

      // every duration zero: no pause, all others floored to one
      program_durations(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      run_random(PhaseItems, 1'b1);

      // every duration at its maximum, streamed with no idling
      calm = 1'b1;
      program_durations(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      run_random(PhaseItems, 1'b0);
      calm = 1'b0;

      program_durations(16'($urandom_range(0, 12)), 16'($urandom_range(0, 12)),
                        16'($urandom_range(0, 12)), 16'($urandom_range(0, 12)),
                        16'($urandom_range(0, 12)));
      run_random(PhaseItems, 1'b1);

      program_durations(16'($urandom_range(1, 40)), 16'($urandom_range(1, 40)),
                        16'($urandom_range(1, 40)), 16'($urandom_range(1, 40)),
                        16'($urandom_range(1, 40)));
      run_random(PhaseItems, 1'b0);

      program_durations(16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), 16'($urandom));
      run_random(PhaseItems, 1'b0);

      calm = 1'b1;
      program_durations(16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)),
                        16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)),
                        16'($urandom_range(0, 6)));
      run_random(PhaseItems, 1'b0);

      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
